@@ hw/rtl/first_fit_run_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// First-fit run allocator assertion macros
// Shared property wrappers for the checker of the allocator's ports.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_RUN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit run allocator package
// Shared widths, sequencer states and the bitmap access bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    // Slot numbers, counts and run lengths are carried with one spare bit.
    localparam int SLOT_W  = 12;
    localparam int FIELD_W = 11;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_RESULT = 4'b0100,
        ST_FILL   = 4'b1000
    } t_state;

    // One write and one read request to the slot bitmap per cycle.
    typedef struct packed {
        logic              we;
        logic              wbit;
        logic [SLOT_W-1:0] wslot;
        logic [SLOT_W-1:0] rslot;
    } t_mem_req;

endpackage

`default_nettype wire

@@ hw/rtl/ffra_bitmap.sv @@
// ----------------------------------------------------------------------------
// Slot bitmap
// One bit per slot, set when the slot is taken. One write and one
// registered read per cycle, addressed by slot number starting at 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_bitmap #(
    parameter int SLOTS = 1024
) (
    input  wire               i_clk,
    input  ffra_pkg::t_mem_req i_req,
    output logic              o_rd_bit
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          r_mem [SLOTS];
    logic [AW-1:0] w_widx;
    logic [AW-1:0] w_ridx;

    // Slot numbers start at 1, storage starts at 0.
    assign w_widx = AW'(i_req.wslot - ffra_pkg::SLOT_W'(1));
    assign w_ridx = AW'(i_req.rslot - ffra_pkg::SLOT_W'(1));

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_widx] <= i_req.wbit;
        end
        o_rd_bit <= r_mem[w_ridx];
    end

endmodule

`default_nettype wire

@@ hw/rtl/ffra_seq.sv @@
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the slot bitmap one slot a cycle: a scan that counts the current
// free run for a reserve, and a fill pass that marks a range taken or free.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_seq #(
    parameter int SLOTS = 1024
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [ffra_pkg::FIELD_W-1:0]      i_cfg_wdata,
    input  wire                               i_s_tvalid,
    input  wire                               i_s_tuser,
    input  wire  [2*ffra_pkg::FIELD_W-1:0]    i_s_tdata,
    output logic                              o_s_tready,
    input  wire                               i_rd_bit,
    output ffra_pkg::t_mem_req                o_mem,
    input  wire                               i_out_free,
    output logic                              o_res_load,
    output logic [ffra_pkg::FIELD_W-1:0]      o_res_grant
);

    localparam int SW  = ffra_pkg::SLOT_W;
    localparam int FW  = ffra_pkg::FIELD_W;
    localparam int CAP = (SLOTS < 2047) ? SLOTS : 2047;
    localparam int RST = (SLOTS < 1024) ? SLOTS : 1024;
    localparam logic [FW-1:0] CAP_CNT = FW'(CAP);
    localparam logic [FW-1:0] RST_CNT = FW'(RST);

    ffra_pkg::t_state r_state;
    logic [FW-1:0]    r_cnt;
    logic [SW-1:0]    r_ptr;
    logic [SW-1:0]    r_hi;
    logic             r_wbit;
    logic [SW-1:0]    r_need;
    logic [SW-1:0]    r_run;
    logic [SW-1:0]    r_grant;
    logic             r_chk_vld;
    logic [SW-1:0]    r_chk_slot;

    logic [FW-1:0] w_start;
    logic [FW-1:0] w_len;
    logic [FW-1:0] w_sat;
    logic [SW-1:0] w_cnt;
    logic [SW-1:0] w_rel_lo;
    logic [SW-1:0] w_rel_end;
    logic [SW-1:0] w_rel_hi;
    logic          w_rel_ok;
    logic          w_accept;
    logic [SW-1:0] w_run_inc;
    logic          w_found;
    logic          w_last;

    assign w_start  = i_s_tdata[FW-1:0];
    assign w_len    = i_s_tdata[2*FW-1:FW];
    assign w_cnt    = {1'b0, r_cnt};
    assign w_accept = i_s_tvalid && o_s_tready;

    // New slot count, held within one and the smaller of the storage depth and 2047.
    always_comb begin
        w_sat = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            w_sat = FW'(1);
        end else if (i_cfg_wdata > CAP_CNT) begin
            w_sat = CAP_CNT;
        end
    end

    // Release range clipped to the slots in use.
    assign w_rel_lo  = (w_start == '0) ? SW'(1) : {1'b0, w_start};
    assign w_rel_end = {1'b0, w_start} + {1'b0, w_len} - SW'(1);
    assign w_rel_hi  = (w_rel_end > w_cnt) ? w_cnt : w_rel_end;
    assign w_rel_ok  = (w_len != '0) && (w_rel_lo <= w_rel_hi);

    // Free run tracking on the slot whose bit has just been read.
    assign w_run_inc = r_run + SW'(1);
    assign w_found   = r_chk_vld && !i_rd_bit && (w_run_inc == r_need);
    assign w_last    = r_chk_vld && (r_chk_slot == w_cnt);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffra_pkg::ST_FILL;
            r_cnt     <= RST_CNT;
            r_ptr     <= SW'(1);
            r_hi      <= {1'b0, RST_CNT};
            r_wbit    <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld  <= (r_state == ffra_pkg::ST_SCAN) && (r_ptr <= w_cnt);
            r_chk_slot <= r_ptr;
            if (i_cfg_we) begin
                // A new slot count starts a clearing pass over its slots.
                r_cnt   <= w_sat;
                r_ptr   <= SW'(1);
                r_hi    <= {1'b0, w_sat};
                r_wbit  <= 1'b0;
                r_state <= ffra_pkg::ST_FILL;
            end else begin
                case (r_state)
                    ffra_pkg::ST_IDLE: begin
                        if (w_accept) begin
                            if (i_s_tuser) begin
                                if (w_rel_ok) begin
                                    r_ptr   <= w_rel_lo;
                                    r_hi    <= w_rel_hi;
                                    r_wbit  <= 1'b0;
                                    r_state <= ffra_pkg::ST_FILL;
                                end
                            end else begin
                                r_need <= {1'b0, w_len};
                                r_run  <= '0;
                                r_ptr  <= SW'(1);
                                if (w_len == '0) begin
                                    r_grant <= '0;
                                    r_state <= ffra_pkg::ST_RESULT;
                                end else begin
                                    r_state <= ffra_pkg::ST_SCAN;
                                end
                            end
                        end
                    end
                    ffra_pkg::ST_SCAN: begin
                        if (r_ptr <= w_cnt) begin
                            r_ptr <= r_ptr + SW'(1);
                        end
                        if (r_chk_vld) begin
                            r_run <= i_rd_bit ? '0 : w_run_inc;
                        end
                        if (w_found) begin
                            r_grant <= r_chk_slot - r_need + SW'(1);
                            r_state <= ffra_pkg::ST_RESULT;
                        end else if (w_last) begin
                            r_grant <= '0;
                            r_state <= ffra_pkg::ST_RESULT;
                        end
                    end
                    ffra_pkg::ST_RESULT: begin
                        if (i_out_free) begin
                            if (r_grant != '0) begin
                                r_ptr   <= r_grant;
                                r_hi    <= r_grant + r_need - SW'(1);
                                r_wbit  <= 1'b1;
                                r_state <= ffra_pkg::ST_FILL;
                            end else begin
                                r_state <= ffra_pkg::ST_IDLE;
                            end
                        end
                    end
                    ffra_pkg::ST_FILL: begin
                        r_ptr <= r_ptr + SW'(1);
                        if (r_ptr == r_hi) begin
                            r_state <= ffra_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ffra_pkg::ST_IDLE;
                    end
                endcase
            end
        end
    end

    // Bitmap access: the fill pass writes, the scan reads, both at the pointer.
    assign o_mem.we    = (r_state == ffra_pkg::ST_FILL);
    assign o_mem.wbit  = r_wbit;
    assign o_mem.wslot = r_ptr;
    assign o_mem.rslot = r_ptr;

    assign o_s_tready  = (r_state == ffra_pkg::ST_IDLE) && !i_cfg_we;
    assign o_res_load  = (r_state == ffra_pkg::ST_RESULT) && i_out_free;
    assign o_res_grant = r_grant[FW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_run_allocator.sv @@
// ----------------------------------------------------------------------------
// First-fit run allocator
// Reserves the lowest run of free consecutive slots of a requested length
// and releases given slot ranges.
// ----------------------------------------------------------------------------
// One request is handled at a time, one slot per cycle on the slot bitmap.
// A reserve scans slots from 1 upward until the run is found or slot_count
// is passed, waits while the grant output register is not free, then marks
// the granted run taken if one was found. A release marks the clipped slots
// free. After reset and after each slot_count write a clearing pass over the
// slot_count slots runs before the first transfer is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_run_allocator #(
    parameter int SLOTS = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration: slot_count.
    input  wire         i_cfg_we,
    input  wire  [10:0] i_cfg_wdata,
    // Request stream.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // [10:0] start_req, [21:11] length, [23:22] zero
    input  wire         i_s_tuser,   // [0] action
    // Grant stream.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [10:0] granted_start, [15:11] zero
);

    localparam int FW = ffra_pkg::FIELD_W;

    ffra_pkg::t_mem_req w_mem;
    logic               w_rd_bit;
    logic               w_out_free;
    logic               w_res_load;
    logic [FW-1:0]      w_res_grant;
    logic               r_m_valid;
    logic [FW-1:0]      r_m_data;

    ffra_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata[2*FW-1:0]),
        .o_s_tready  (o_s_tready),
        .i_rd_bit    (w_rd_bit),
        .o_mem       (w_mem),
        .i_out_free  (w_out_free),
        .o_res_load  (w_res_load),
        .o_res_grant (w_res_grant)
    );

    ffra_bitmap #(
        .SLOTS (SLOTS)
    ) u_bitmap (
        .i_clk    (i_clk),
        .i_req    (w_mem),
        .o_rd_bit (w_rd_bit)
    );

    // Grant output register.
    assign w_out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_m_data <= w_res_grant;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'b0, r_m_data};

endmodule

`default_nettype wire

@@ hw/rtl/ffra_checker.sv @@
// ----------------------------------------------------------------------------
// First-fit run allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_run_allocator_defines.svh"

module ffra_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_cfg_we,
    input wire [10:0] i_cfg_wdata,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire [23:0] i_s_tdata,
    input wire        i_s_tuser,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [15:0] o_m_tdata
);

    // A stalled grant holds.
    `FFRA_ASSERT_NEXT(a_grant_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "grant changed while stalled")

    // Every accepted reserve makes the block busy in the cycle after it. An empty
    // release leaves the block ready.
    `FFRA_ASSERT_NEXT(a_busy_after_req, i_s_tvalid && o_s_tready && !i_s_tuser, !o_s_tready, "ready right after a reserve")

    // A slot_count write starts a clearing pass.
    `FFRA_ASSERT_NEXT(a_clear_after_cfg, i_cfg_we, !o_s_tready, "ready right after a slot count write")

    // Leaving reset starts the clearing pass.
    `FFRA_ASSERT_NOW(a_clear_after_rst, $rose(i_rst_n), !o_s_tready, "ready right after reset")

endmodule

bind first_fit_run_allocator ffra_checker u_ffra_checker (.*);

`default_nettype wire
